/* hdl/q2e_pkg.sv */
// Shared widths, constants, types and helpers for the quaternion to Euler angle block.
package q2e_pkg;

   localparam int COMPONENT_BITS_DEF = 16;
   localparam int CORDIC_STAGES_DEF  = 16;

   localparam int Q28_W      = 32;   // one product in Q.28, magnitude up to 2^30
   localparam int SUM_W      = 36;   // 2*(a+b) and 1-2*(a+b) in Q.28
   localparam int CORDIC_W   = 38;   // CORDIC x/y incl. gain growth
   localparam int ANG_W      = 34;   // angle accumulator, 2^-23 degree
   localparam int ROUND_W    = ANG_W - 16;   // angle in 1/128 degree
   localparam int SQRT_CELLS = 29;   // root of up to 2^56 needs 29 bits
   localparam int SQRT_W     = 58;
   localparam int SQRT_TOP   = 56;   // radicand is 2^56 - s^2
   localparam int ATAN_LEN   = 24;

   localparam int YAW_ROLL_LIMIT = 23040;
   localparam int PITCH_LIMIT    = 11520;

   localparam logic signed [SUM_W-1:0] ONE_Q28 = SUM_W'(1) << 28;
   localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(90) << 23;

   // atan(2^-i) in 2^-23 degree
   localparam logic signed [ANG_W-1:0] ATAN_TABLE [ATAN_LEN] = '{
      34'sd377487360, 34'sd222843801, 34'sd117744544, 34'sd59768969,
      34'sd30000467,  34'sd15014858,  34'sd7509261,   34'sd3754860,
      34'sd1877459,   34'sd938733,    34'sd469367,    34'sd234683,
      34'sd117342,    34'sd58671,     34'sd29335,     34'sd14668,
      34'sd7334,      34'sd3667,      34'sd1833,      34'sd917,
      34'sd458,       34'sd229,       34'sd115,       34'sd57
   };

   typedef struct packed {
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic signed [ANG_W-1:0]    ang;
   } cordic_vec_type;

   typedef struct packed {
      logic [SQRT_W-1:0] rem;
      logic [SQRT_W-1:0] root;
   } sqrt_state_type;

   function automatic logic signed [ROUND_W-1:0] sat_angle(
      input logic signed [ROUND_W-1:0] a,
      input int                        lim
   );
      logic signed [ROUND_W-1:0] lim_s;
      lim_s = ROUND_W'(lim);
      if (a > lim_s) begin
         return lim_s;
      end else if (a < -lim_s) begin
         return -lim_s;
      end
      return a;
   endfunction

endpackage

/* hdl/quaternion_to_euler_zyx.sv */
// Top level: quaternion (Q1.14) to ZYX Euler angles in 1/128 degree.
//
// Usage
//  - Request: drive req_quat_w/x/y/z and raise start. A transaction is taken
//    at every rising edge with start high and busy low; busy is never raised,
//    so a new quaternion may be presented every cycle.
//  - Response: exactly one transaction per request. rsp_valid is high for one
//    cycle with rsp_yaw_angle, rsp_pitch_angle, rsp_roll_angle and
//    rsp_pitch_clamped; the receiver cannot hold it off.
//  - Throughput: one transaction per cycle. Latency is set by the pitch path:
//    the input, product, sum, absolute-value, square and radicand registers,
//    29 square-root cells, then the CORDIC chain.
//  - Roll and yaw run their CORDIC chains early and wait on a delay line.
//  - Reset (synchronous): clears the valid pipeline; results of requests in
//    flight are dropped. There is no receiver back-pressure to handle.
//  - Pitch at or past +-90 degrees is clamped and flagged.
module quaternion_to_euler_zyx import q2e_pkg::*; #(
   parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
   parameter int CORDIC_STAGES  = CORDIC_STAGES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic signed [COMPONENT_BITS-1:0] req_quat_w,
   input  logic signed [COMPONENT_BITS-1:0] req_quat_x,
   input  logic signed [COMPONENT_BITS-1:0] req_quat_y,
   input  logic signed [COMPONENT_BITS-1:0] req_quat_z,
   output logic                             rsp_valid,
   output logic signed [15:0]               rsp_yaw_angle,
   output logic signed [14:0]               rsp_pitch_angle,
   output logic signed [15:0]               rsp_roll_angle,
   output logic                             rsp_pitch_clamped
);

   // product scaling to Q.28
   localparam int SHR = (COMPONENT_BITS >= 16) ? 2 * (COMPONENT_BITS - 16) : 0;
   localparam int SHL = (COMPONENT_BITS <  16) ? 2 * (16 - COMPONENT_BITS) : 0;
   localparam int ANG_LAT = CORDIC_STAGES + 2;            // atan2 unit
   localparam int SIDE_DLY = 3 + SQRT_CELLS;              // abs, square, radicand, root
   localparam int CLAMP_DLY = SIDE_DLY + ANG_LAT;
   localparam int LATENCY = 6 + SQRT_CELLS + ANG_LAT + 1;

   function automatic logic signed [Q28_W-1:0] to_q28(
      input logic signed [COMPONENT_BITS-1:0] a,
      input logic signed [COMPONENT_BITS-1:0] b
   );
      logic signed [2*COMPONENT_BITS-1:0] p;
      logic signed [63:0]                 pe;
      p  = a * b;
      pe = 64'(p);
      return Q28_W'((pe >>> SHR) <<< SHL);
   endfunction

   // ---- stage 0: input registers
   logic signed [COMPONENT_BITS-1:0] w_ff, x_ff, y_ff, z_ff;
   logic [LATENCY-2:0] vld_ff, vld_in;

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         w_ff <= req_quat_w;
         x_ff <= req_quat_x;
         y_ff <= req_quat_y;
         z_ff <= req_quat_z;
      end
   end

   assign vld_in = {vld_ff[LATENCY-3:0], start && !busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // ---- stage 1: the nine products
   logic signed [Q28_W-1:0] wx_ff, yz_ff, xx_ff, yy_ff, wz_ff, xy_ff, zz_ff, wy_ff, zx_ff;

   always_ff @(posedge clock) begin
      wx_ff <= to_q28(w_ff, x_ff);
      yz_ff <= to_q28(y_ff, z_ff);
      xx_ff <= to_q28(x_ff, x_ff);
      yy_ff <= to_q28(y_ff, y_ff);
      wz_ff <= to_q28(w_ff, z_ff);
      xy_ff <= to_q28(x_ff, y_ff);
      zz_ff <= to_q28(z_ff, z_ff);
      wy_ff <= to_q28(w_ff, y_ff);
      zx_ff <= to_q28(z_ff, x_ff);
   end

   // ---- stage 2: sines and cosines
   logic signed [SUM_W-1:0] sr_ff, cr_ff, sy_ff, cy_ff, s_ff;

   always_ff @(posedge clock) begin
      sr_ff <= (SUM_W'(wx_ff) + SUM_W'(yz_ff)) <<< 1;
      cr_ff <= ONE_Q28 - ((SUM_W'(xx_ff) + SUM_W'(yy_ff)) <<< 1);
      sy_ff <= (SUM_W'(wz_ff) + SUM_W'(xy_ff)) <<< 1;
      cy_ff <= ONE_Q28 - ((SUM_W'(yy_ff) + SUM_W'(zz_ff)) <<< 1);
      s_ff  <= (SUM_W'(wy_ff) - SUM_W'(zx_ff)) <<< 1;
   end

   // ---- roll and yaw: CORDIC now, wait for pitch afterwards
   logic signed [ROUND_W-1:0] roll_raw, yaw_raw, pitch_raw;
   logic [2*ROUND_W-1:0]      ry_dly;

   q2e_atan2 #(.STAGES(CORDIC_STAGES)) u_roll (
      .clock     (clock),
      .y_in      (CORDIC_W'(sr_ff)),
      .x_in      (CORDIC_W'(cr_ff)),
      .angle_out (roll_raw)
   );

   q2e_atan2 #(.STAGES(CORDIC_STAGES)) u_yaw (
      .clock     (clock),
      .y_in      (CORDIC_W'(sy_ff)),
      .x_in      (CORDIC_W'(cy_ff)),
      .angle_out (yaw_raw)
   );

   q2e_delay #(.WIDTH(2*ROUND_W), .DEPTH(SIDE_DLY)) u_ry_dly (
      .clock (clock),
      .d_in  ({roll_raw, yaw_raw}),
      .d_out (ry_dly)
   );

   // ---- pitch: clamp test, then cosine = sqrt(1 - s^2)
   logic                    clamp_now;
   logic [SUM_W-1:0]        abs_s;
   logic [27:0]             abs28_ff;
   logic [55:0]             sq_ff;
   logic [SQRT_W-1:0]       rad_ff;
   logic [1:0]              clamp_dly;
   logic [SUM_W-1:0]        s_dly;
   sqrt_state_type          root_chain [SQRT_CELLS+1];

   always_comb begin
      clamp_now = (s_ff >= ONE_Q28) || (s_ff <= -ONE_Q28);
      abs_s     = s_ff[SUM_W-1] ? SUM_W'(-s_ff) : SUM_W'(s_ff);
   end

   always_ff @(posedge clock) begin
      abs28_ff <= clamp_now ? '0 : abs_s[27:0];
      sq_ff    <= abs28_ff * abs28_ff;
      rad_ff   <= (SQRT_W'(1) << SQRT_TOP) - SQRT_W'(sq_ff);
   end

   assign root_chain[0].rem  = rad_ff;
   assign root_chain[0].root = '0;

   for (genvar j = 0; j < SQRT_CELLS; j++) begin : g_sqrt
      q2e_sqrt_cell #(.BIT_POS(2 * (SQRT_CELLS - 1 - j))) u_cell (
         .clock (clock),
         .d_in  (root_chain[j]),
         .d_out (root_chain[j+1])
      );
   end

   q2e_delay #(.WIDTH(SUM_W), .DEPTH(SIDE_DLY)) u_s_dly (
      .clock (clock),
      .d_in  (s_ff),
      .d_out (s_dly)
   );

   q2e_delay #(.WIDTH(2), .DEPTH(CLAMP_DLY)) u_clamp_dly (
      .clock (clock),
      .d_in  ({clamp_now, s_ff[SUM_W-1]}),
      .d_out (clamp_dly)
   );

   q2e_atan2 #(.STAGES(CORDIC_STAGES)) u_pitch (
      .clock     (clock),
      .y_in      (CORDIC_W'($signed(s_dly))),
      .x_in      (CORDIC_W'($signed({1'b0, root_chain[SQRT_CELLS].root[SQRT_CELLS-1:0]}))),
      .angle_out (pitch_raw)
   );

   // ---- response registers
   logic                      rsp_valid_ff;
   logic signed [ROUND_W-1:0] yaw_in, roll_in, pitch_in;
   logic signed [15:0]        yaw_ff, roll_ff;
   logic signed [14:0]        pitch_ff;
   logic                      clamp_ff;

   always_comb begin
      roll_in = sat_angle(ry_dly[2*ROUND_W-1:ROUND_W], YAW_ROLL_LIMIT);
      yaw_in  = sat_angle(ry_dly[ROUND_W-1:0], YAW_ROLL_LIMIT);
      if (clamp_dly[1]) begin
         pitch_in = clamp_dly[0] ? -ROUND_W'(PITCH_LIMIT) : ROUND_W'(PITCH_LIMIT);
      end else begin
         pitch_in = sat_angle(pitch_raw, PITCH_LIMIT);
      end
   end

   always_ff @(posedge clock) begin
      yaw_ff   <= yaw_in[15:0];
      roll_ff  <= roll_in[15:0];
      pitch_ff <= pitch_in[14:0];
      clamp_ff <= clamp_dly[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vld_ff[LATENCY-2];
      end
   end

   assign busy              = 1'b0;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_yaw_angle     = yaw_ff;
   assign rsp_pitch_angle   = pitch_ff;
   assign rsp_roll_angle    = roll_ff;
   assign rsp_pitch_clamped = clamp_ff;

endmodule

/* hdl/q2e_delay.sv */
// Fixed-length register shift line for side data.
module q2e_delay import q2e_pkg::*; #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] d_in,
   output logic [WIDTH-1:0] d_out
);

   logic [WIDTH-1:0] line_ff [DEPTH];

   always_ff @(posedge clock) begin
      line_ff[0] <= d_in;
      for (int i = 1; i < DEPTH; i++) begin
         line_ff[i] <= line_ff[i-1];
      end
   end

   assign d_out = line_ff[DEPTH-1];

endmodule

/* hdl/q2e_sqrt_cell.sv */
// One restoring square-root step, one result bit, registered.
module q2e_sqrt_cell import q2e_pkg::*; #(
   parameter int BIT_POS = 0
) (
   input  logic           clock,
   input  sqrt_state_type d_in,
   output sqrt_state_type d_out
);

   localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << BIT_POS;

   sqrt_state_type q_ff, q_in;
   logic [SQRT_W-1:0] trial;

   always_comb begin
      trial = d_in.root + BIT;
      if (d_in.rem >= trial) begin
         q_in.rem  = d_in.rem - trial;
         q_in.root = (d_in.root >> 1) + BIT;
      end else begin
         q_in.rem  = d_in.rem;
         q_in.root = d_in.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign d_out = q_ff;

endmodule

/* hdl/q2e_cordic_cell.sv */
// One vectoring CORDIC micro-rotation, registered.
module q2e_cordic_cell import q2e_pkg::*; #(
   parameter int                      SHIFT = 0,
   parameter logic signed [ANG_W-1:0] ATAN  = '0
) (
   input  logic           clock,
   input  cordic_vec_type d_in,
   output cordic_vec_type d_out
);

   cordic_vec_type q_ff, q_in;
   logic signed [CORDIC_W-1:0] dx, dy;

   always_comb begin
      dx = d_in.y >>> SHIFT;
      dy = d_in.x >>> SHIFT;
      if (!d_in.y[CORDIC_W-1]) begin
         q_in.x   = d_in.x + dx;
         q_in.y   = d_in.y - dy;
         q_in.ang = d_in.ang + ATAN;
      end else begin
         q_in.x   = d_in.x - dx;
         q_in.y   = d_in.y + dy;
         q_in.ang = d_in.ang - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign d_out = q_ff;

endmodule

/* hdl/q2e_atan2.sv */
// Pipelined atan2: quarter-turn pre-rotation, chain of CORDIC cells, rounding.
module q2e_atan2 import q2e_pkg::*; #(
   parameter int STAGES = CORDIC_STAGES_DEF
) (
   input  logic                       clock,
   input  logic signed [CORDIC_W-1:0] y_in,
   input  logic signed [CORDIC_W-1:0] x_in,
   output logic signed [ROUND_W-1:0]  angle_out
);

   cordic_vec_type pre_ff, pre_in;
   cordic_vec_type chain [STAGES+1];
   logic zero_ff, zero_in, zero_dly;
   logic signed [ROUND_W-1:0] out_ff, out_in;
   logic signed [ANG_W-1:0]   ang_rnd;

   always_comb begin
      zero_in = (x_in == '0) && (y_in == '0);
      pre_in.x   = x_in;
      pre_in.y   = y_in;
      pre_in.ang = '0;
      if (x_in[CORDIC_W-1]) begin
         if (!y_in[CORDIC_W-1]) begin
            pre_in.x   = y_in;
            pre_in.y   = -x_in;
            pre_in.ang = QUARTER_TURN;
         end else begin
            pre_in.x   = -y_in;
            pre_in.y   = x_in;
            pre_in.ang = -QUARTER_TURN;
         end
      end
   end

   always_ff @(posedge clock) begin
      pre_ff  <= pre_in;
      zero_ff <= zero_in;
   end

   assign chain[0] = pre_ff;

   for (genvar i = 0; i < STAGES; i++) begin : g_cell
      q2e_cordic_cell #(
         .SHIFT (i),
         .ATAN  (ATAN_TABLE[i])
      ) u_cell (
         .clock (clock),
         .d_in  (chain[i]),
         .d_out (chain[i+1])
      );
   end

   q2e_delay #(.WIDTH(1), .DEPTH(STAGES)) u_zero_dly (
      .clock (clock),
      .d_in  (zero_ff),
      .d_out (zero_dly)
   );

   // round to 1/128 degree, halves upward
   always_comb begin
      ang_rnd = (chain[STAGES].ang + (ANG_W'(1) << 15)) >>> 16;
      out_in  = zero_dly ? '0 : ang_rnd[ROUND_W-1:0];
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign angle_out = out_ff;

endmodule

/* hdl/q2e_checker.sv */
// Port-level checks for the quaternion to Euler angle block, with its bind.
module q2e_checker import q2e_pkg::*; #(
   parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
   parameter int CORDIC_STAGES  = CORDIC_STAGES_DEF
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic signed [COMPONENT_BITS-1:0] req_quat_w,
   input logic                             rsp_valid,
   input logic signed [15:0]               rsp_yaw_angle,
   input logic signed [14:0]               rsp_pitch_angle,
   input logic signed [15:0]               rsp_roll_angle,
   input logic                             rsp_pitch_clamped
);

   localparam int LATENCY = 38 + CORDIC_STAGES;

   logic unused_w;
   assign unused_w = ^req_quat_w;

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("response without a matching request");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response straight after reset");

   a_clamp_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pitch_clamped) |->
         (rsp_pitch_angle == 15'sd11520 || rsp_pitch_angle == -15'sd11520))
      else $error("clamped pitch not at ninety degrees");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_yaw_angle <= 16'sd23040 && rsp_yaw_angle >= -16'sd23040 &&
                     rsp_roll_angle <= 16'sd23040 && rsp_roll_angle >= -16'sd23040))
      else $error("yaw or roll out of range");

endmodule

bind quaternion_to_euler_zyx q2e_checker #(
   .COMPONENT_BITS (COMPONENT_BITS),
   .CORDIC_STAGES  (CORDIC_STAGES)
) u_q2e_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_quat_w        (req_quat_w),
   .rsp_valid         (rsp_valid),
   .rsp_yaw_angle     (rsp_yaw_angle),
   .rsp_pitch_angle   (rsp_pitch_angle),
   .rsp_roll_angle    (rsp_roll_angle),
   .rsp_pitch_clamped (rsp_pitch_clamped)
);

/* tb/sv/tb_top.sv */
// Testbench for quaternion_to_euler_zyx: random and directed quaternions checked against a predictor.
module tb_top import q2e_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   // Fixed-point unit and CORDIC stage count of the angle computation, latency and cycle cap
   localparam longint UNIT_Q28  = 64'sd1 << 28;
   localparam int     STAGES    = 16;
   localparam int     LATENCY   = 38 + STAGES;
   localparam longint CYCLE_CAP = 400000;

   typedef struct {
      logic signed [15:0] w, x, y, z;
   } quat_type;

   typedef struct {
      logic signed [15:0] yaw;
      logic signed [14:0] pitch;
      logic signed [15:0] roll;
      logic               clamped;
   } euler_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [15:0] req_quat_w = '0, req_quat_x = '0, req_quat_y = '0, req_quat_z = '0;
   logic rsp_valid;
   logic signed [15:0] rsp_yaw_angle, rsp_roll_angle;
   logic signed [14:0] rsp_pitch_angle;
   logic rsp_pitch_clamped;

   quat_type  pending_quats[$];
   euler_type expected_angles[$];
   int     error_count = 0;
   longint cycle_count = 0;
   bit     allow_gaps = 1'b1;
   bit     hold_for_drain = 1'b0;   // sender pauses until every result is back
   int     gap_left = 0;

   quaternion_to_euler_zyx dut (
      .clock, .reset, .start, .busy,
      .req_quat_w, .req_quat_x, .req_quat_y, .req_quat_z,
      .rsp_valid, .rsp_yaw_angle, .rsp_pitch_angle, .rsp_roll_angle, .rsp_pitch_clamped
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ---- predictor -------------------------------------------------------
   // floor shift right, as the hardware does
   function automatic longint floor_shr(longint v, int k);
      return v >>> k;
   endfunction

   function automatic longint floor_isqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return longint'(res);
   endfunction

   // vectoring CORDIC atan2, result in 1/128 degree before saturation
   function automatic longint atan2_deg128(longint sy, longint cx);
      longint ang, t, dx, dy;
      ang = 0;
      if (cx == 0 && sy == 0) return 0;
      if (cx < 0) begin
         if (sy >= 0) begin
            t = cx; cx = sy; sy = -t;
            ang = 64'sd90 << 23;
         end else begin
            t = cx; cx = -sy; sy = t;
            ang = -(64'sd90 << 23);
         end
      end
      for (int i = 0; i < STAGES; i++) begin
         dx = floor_shr(sy, i);
         dy = floor_shr(cx, i);
         if (sy >= 0) begin
            cx += dx; sy -= dy; ang += longint'(ATAN_TABLE[i]);
         end else begin
            cx -= dx; sy += dy; ang -= longint'(ATAN_TABLE[i]);
         end
      end
      return floor_shr(ang + (64'sd1 << 15), 16);
   endfunction

   function automatic longint clip(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic euler_type predict_angles(quat_type q);
      longint w, x, y, z, sr, cr, sy, cy, s, abs_s, c;
      euler_type e;
      w = q.w; x = q.x; y = q.y; z = q.z;
      sr = 2 * (w * x + y * z);
      cr = UNIT_Q28 - 2 * (x * x + y * y);
      sy = 2 * (w * z + x * y);
      cy = UNIT_Q28 - 2 * (y * y + z * z);
      e.roll = 16'(clip(atan2_deg128(sr, cr), YAW_ROLL_LIMIT));
      e.yaw  = 16'(clip(atan2_deg128(sy, cy), YAW_ROLL_LIMIT));
      s = 2 * (w * y - z * x);
      abs_s = s < 0 ? -s : s;
      if (abs_s >= UNIT_Q28) begin
         e.pitch = s < 0 ? -15'sd11520 : 15'sd11520;
         e.clamped = 1'b1;
      end else begin
         c = floor_isqrt((64'd1 << 56) - longint'(abs_s) * abs_s);
         e.pitch = 15'(clip(atan2_deg128(s, c), PITCH_LIMIT));
         e.clamped = 1'b0;
      end
      return e;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   function automatic void queue_quat(quat_type q);
      pending_quats.insert(pending_quats.size(), q);
   endfunction

   // ---- driver: changes inputs at the falling edge ----------------------
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (hold_for_drain && expected_angles.size() != 0) begin
         start <= 1'b0;
      end else if (gap_left > 0) begin
         gap_left <= gap_left - 1;
         start <= 1'b0;
      end else if (allow_gaps && $urandom_range(0, 15) == 0) begin
         gap_left <= $urandom_range(1, 18) - 1;
         start <= 1'b0;
      end else if (pending_quats.size() != 0) begin
         quat_type q;
         q = pending_quats[0];
         pending_quats.delete(0);
         req_quat_w <= q.w; req_quat_x <= q.x; req_quat_y <= q.y; req_quat_z <= q.z;
         start <= 1'b1;
      end else begin
         start <= 1'b0;
      end
   end

   // ---- monitor: samples at the rising edge -----------------------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && start && !busy) begin
         quat_type q;
         q.w = req_quat_w; q.x = req_quat_x; q.y = req_quat_y; q.z = req_quat_z;
         expected_angles.insert(expected_angles.size(), predict_angles(q));
      end
      if (!reset && rsp_valid) begin
         if (expected_angles.size() == 0) begin
            report_mismatch("unexpected transaction", 1, 0);
         end else begin
            euler_type e;
            e = expected_angles[0];
            expected_angles.delete(0);
            if (rsp_yaw_angle !== e.yaw) report_mismatch("yaw", rsp_yaw_angle, e.yaw);
            if (rsp_pitch_angle !== e.pitch) report_mismatch("pitch", rsp_pitch_angle, e.pitch);
            if (rsp_roll_angle !== e.roll) report_mismatch("roll", rsp_roll_angle, e.roll);
            if (rsp_pitch_clamped !== e.clamped)
               report_mismatch("clamp flag", rsp_pitch_clamped, e.clamped);
         end
      end
      if (cycle_count > CYCLE_CAP) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic logic signed [15:0] rand_comp();
      return 16'($urandom);
   endfunction

   function automatic quat_type make_quat(int w, int x, int y, int z);
      quat_type q;
      q.w = 16'(w); q.x = 16'(x); q.y = 16'(y); q.z = 16'(z);
      return q;
   endfunction

   // near-unit quaternion with random direction; scale ~2^14
   function automatic quat_type rand_unitish();
      quat_type q;
      int a, b, c, d;
      longint n;
      a = $urandom_range(0, 32767) - 16384; b = $urandom_range(0, 32767) - 16384;
      c = $urandom_range(0, 32767) - 16384; d = $urandom_range(0, 32767) - 16384;
      n = floor_isqrt(longint'(a) * a + longint'(b) * b + longint'(c) * c + longint'(d) * d);
      if (n == 0) n = 1;
      q = make_quat(a * 16384 / n, b * 16384 / n, c * 16384 / n, d * 16384 / n);
      return q;
   endfunction

   initial begin
      quat_type q;
      int k;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: identity, zero, extremes, gimbal lock both ways, yaw 180
      queue_quat(make_quat(16384, 0, 0, 0));
      queue_quat(make_quat(0, 0, 0, 0));
      queue_quat(make_quat(-16384, -16384, -16384, -16384));
      queue_quat(make_quat(16384, 16384, 16384, 16384));
      queue_quat(make_quat(-32768, -32768, -32768, -32768));
      queue_quat(make_quat(32767, 32767, 32767, 32767));
      queue_quat(make_quat(32767, -32768, 32767, -32768));
      queue_quat(make_quat(11585, 0, 11585, 0));
      queue_quat(make_quat(11585, 0, -11585, 0));
      queue_quat(make_quat(11586, 0, 11586, 0));
      queue_quat(make_quat(0, 0, 0, 16384));
      queue_quat(make_quat(0, 16384, 0, 0));
      queue_quat(make_quat(0, 0, 16384, 0));
      queue_quat(make_quat(11585, 11585, 0, 0));
      queue_quat(make_quat(11585, -11585, 0, 0));
      queue_quat(make_quat(11585, 0, 0, -11585));
      queue_quat(make_quat(8192, 8192, 8192, 8192));
      queue_quat(make_quat(8192, -8192, 8192, 8192));

      // pause until the pipeline drains; the last transaction is taken first
      wait (pending_quats.size() == 0);
      @(negedge clock);
      hold_for_drain = 1'b1;
      wait (expected_angles.size() == 0);
      @(negedge clock);
      hold_for_drain = 1'b0;

      for (k = 0; k < 800; k++) begin
         if (k == 650) begin
            wait (pending_quats.size() == 0);
            allow_gaps = 1'b0;
         end
         case ($urandom_range(0, 9))
            0, 1: q = make_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
            2: begin
               // around gimbal lock
               int v;
               v = 11585 + $urandom_range(0, 6) - 3;
               q = make_quat(v, $urandom_range(0, 8) - 4, ($urandom_range(0, 1) ? v : -v),
                             $urandom_range(0, 8) - 4);
            end
            default: q = rand_unitish();
         endcase
         queue_quat(q);
         if (pending_quats.size() > 32) wait (pending_quats.size() < 16);
      end

      wait (pending_quats.size() == 0);
      wait (expected_angles.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
